// ----- rtl/vfb_pkg.sv -----
// Shared types and action codes for the voxel framebuffer blend block.
package vfb_pkg;

  localparam logic [2:0] ACT_SET   = 3'd0;
  localparam logic [2:0] ACT_BLEND = 3'd1;
  localparam logic [2:0] ACT_DIM   = 3'd2;
  localparam logic [2:0] ACT_FILL  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [3:0] pos_z;
    logic [7:0] new_red;
    logic [7:0] new_green;
    logic [7:0] new_blue;
    logic [7:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_of_cube;
  } out_item_t;

endpackage

// ----- rtl/vfb_mix.sv -----
// Per-channel alpha mixer: registered products, then rounding divide by 255.
module vfb_mix (
  input  logic          clk,
  input  logic          load,
  input  logic          dim,
  input  vfb_pkg::rgb_t old_color,
  input  vfb_pkg::rgb_t new_color,
  input  logic [7:0]    weight,
  output vfb_pkg::rgb_t mixed
);

  logic [7:0]  old_c [3];
  logic [7:0]  new_c [3];
  logic [7:0]  mix_c [3];
  logic [15:0] pa_r  [3];
  logic [15:0] pb_r  [3];
  logic [7:0]  old_k;

  assign old_c[0] = old_color.red;
  assign old_c[1] = old_color.green;
  assign old_c[2] = old_color.blue;
  assign new_c[0] = new_color.red;
  assign new_c[1] = new_color.green;
  assign new_c[2] = new_color.blue;

  // Dimming scales the old color by weight; blending weights it by 255 - weight.
  assign old_k = dim ? weight : 8'(8'd255 - weight);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 3; k++) begin
        pa_r[k] <= 16'(old_c[k]) * 16'(old_k);
        pb_r[k] <= dim ? 16'd0 : 16'(new_c[k]) * 16'(weight);
      end
    end
  end

  // The sum stays below 65536, where (s + 1 + (s >> 8)) >> 8 equals s / 255.
  always_comb begin
    logic [16:0] s;
    logic [16:0] q;
    s = '0;
    q = '0;
    for (int k = 0; k < 3; k++) begin
      s = 17'(pa_r[k]) + 17'(pb_r[k]) + 17'd127;
      q = 17'(s + 17'd1 + (s >> 8)) >> 8;
      mix_c[k] = q[7:0];
    end
  end

  assign mixed.red   = mix_c[0];
  assign mixed.green = mix_c[1];
  assign mixed.blue  = mix_c[2];

endmodule

// ----- rtl/voxel_framebuffer_blend.sv -----
// Top level of the voxel framebuffer: RGB voxel store with set, blend, dim, fill and read.
//
// The block holds one 24-bit RGB color for each voxel of a SIDE x SIDE x SIDE cube in
// a single synchronous memory. Every input transaction on the in_ channel names one
// action and yields exactly one output transaction on the out_ channel.
// Set, blend and read address one voxel; a coordinate at or beyond SIDE leaves the
// store untouched and returns out_of_cube. Dim and fill walk the whole store and
// return zeros. Unused action codes return zeros and change nothing.
// The block works on one transaction at a time. Blend is a read-modify-write through
// the memory's registered read port and the mixer's registered multiply stage, and
// dim and fill sweep the store one voxel per cycle.
// After reset a clearing pass writes zero into all SIDE^3 voxels, one per cycle, with
// in_stall held high; configuration does not exist, so nothing else waits on it.
// A finished result sits in an output register; while out_stall holds it there the
// block still accepts the next transaction and works it up to its result, which then
// waits until the output register frees.
module voxel_framebuffer_blend #(
  parameter int SIDE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vfb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vfb_pkg::out_item_t out_data
);

  localparam int DEPTH = SIDE * SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_DIM_ISSUE,
    ST_DIM_DRAIN,
    ST_VOX,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [AW-1:0]      cnt_r;
  vfb_pkg::in_item_t  item_r;
  vfb_pkg::out_item_t res_r;
  vfb_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               out_load;
  logic               p1_r;
  logic               p2_r;
  logic [AW-1:0]      a1_r;
  logic [AW-1:0]      a2_r;

  // Voxel memory with one write and one registered read port.
  logic [23:0]        mem [DEPTH];
  logic [23:0]        rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [23:0]        mem_wd;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  vfb_pkg::rgb_t      old_color;
  vfb_pkg::rgb_t      item_color;
  vfb_pkg::rgb_t      in_color;
  vfb_pkg::rgb_t      mix_color;
  logic               in_cube;
  logic [AW-1:0]      in_addr;

  assign in_cube = ({1'b0, in_data.pos_x} < 5'(SIDE)) &&
                   ({1'b0, in_data.pos_y} < 5'(SIDE)) &&
                   ({1'b0, in_data.pos_z} < 5'(SIDE));

  // Voxel (x, y, z) lives at (x * SIDE + y) * SIDE + z.
  assign in_addr = AW'((32'(in_data.pos_x) * 32'(SIDE) + 32'(in_data.pos_y)) * 32'(SIDE)
                       + 32'(in_data.pos_z));

  assign in_color.red     = in_data.new_red;
  assign in_color.green   = in_data.new_green;
  assign in_color.blue    = in_data.new_blue;
  assign item_color.red   = item_r.new_red;
  assign item_color.green = item_r.new_green;
  assign item_color.blue  = item_r.new_blue;
  assign old_color        = rdata_r;

  // The output register takes a finished result when it is empty or being drained.
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // The read data register feeds the mixer's product registers, whose mixed result is
  // written back from there, so a dim sweep keeps one read and one write in flight
  // per cycle, always on different voxels.
  vfb_mix u_mix (
    .clk       (clk),
    .load      (p1_r),
    .dim       (item_r.action == vfb_pkg::ACT_DIM),
    .old_color (old_color),
    .new_color (item_color),
    .weight    (item_r.weight),
    .mixed     (mix_color)
  );

  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = cnt_r;
    mem_wd  = '0;
    rd_en   = 1'b0;
    rd_addr = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wd = item_color;
      end
      ST_IDLE: begin
        if (in_valid && in_cube) begin
          if (in_data.action == vfb_pkg::ACT_SET) begin
            mem_we = 1'b1;
            mem_wa = in_addr;
            mem_wd = in_color;
          end
          if (in_data.action == vfb_pkg::ACT_BLEND || in_data.action == vfb_pkg::ACT_READ)
          begin
            rd_en   = 1'b1;
            rd_addr = in_addr;
          end
        end
      end
      ST_DIM_ISSUE: begin
        rd_en = 1'b1;
        if (p2_r) begin
          mem_we = 1'b1;
          mem_wa = a2_r;
          mem_wd = mix_color;
        end
      end
      ST_DIM_DRAIN: begin
        if (p2_r) begin
          mem_we = 1'b1;
          mem_wa = a2_r;
          mem_wd = mix_color;
        end
      end
      ST_VOX: begin
        if (p2_r && item_r.action == vfb_pkg::ACT_BLEND) begin
          mem_we = 1'b1;
          mem_wa = a2_r;
          mem_wd = mix_color;
        end
      end
      ST_DONE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
    end else begin
      p1_r <= rd_en;
      a1_r <= rd_addr;
      p2_r <= p1_r;
      a2_r <= a1_r;
      if (out_load) begin
        out_data_r  <= res_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (cnt_r == LAST) begin
            cnt_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            cnt_r  <= '0;
            unique case (in_data.action)
              vfb_pkg::ACT_SET: begin
                if (in_cube) begin
                  res_r <= '{in_data.new_red, in_data.new_green, in_data.new_blue, 1'b0};
                end else begin
                  res_r <= '{8'd0, 8'd0, 8'd0, 1'b1};
                end
                state_r <= ST_DONE;
              end
              vfb_pkg::ACT_BLEND, vfb_pkg::ACT_READ: begin
                if (in_cube) begin
                  res_r   <= '0;
                  state_r <= ST_VOX;
                end else begin
                  res_r   <= '{8'd0, 8'd0, 8'd0, 1'b1};
                  state_r <= ST_DONE;
                end
              end
              vfb_pkg::ACT_DIM: begin
                res_r   <= '0;
                state_r <= ST_DIM_ISSUE;
              end
              vfb_pkg::ACT_FILL: begin
                res_r   <= '0;
                state_r <= ST_FILL;
              end
              default: begin
                res_r   <= '0;
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_FILL: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == LAST) begin
            state_r <= ST_DONE;
          end
        end
        ST_DIM_ISSUE: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == LAST) begin
            state_r <= ST_DIM_DRAIN;
          end
        end
        ST_DIM_DRAIN: begin
          if (p2_r && a2_r == LAST) begin
            state_r <= ST_DONE;
          end
        end
        ST_VOX: begin
          if (p1_r && item_r.action == vfb_pkg::ACT_READ) begin
            res_r   <= '{old_color.red, old_color.green, old_color.blue, 1'b0};
            state_r <= ST_DONE;
          end else if (p2_r) begin
            res_r   <= '{mix_color.red, mix_color.green, mix_color.blue, 1'b0};
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new result only ever enters the output register from the result-ready state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("output became valid outside the result state");

  // While idle, the memory is only written by an offered set transaction.
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_IDLE) |-> (in_valid && in_data.action == vfb_pkg::ACT_SET))
    else $error("memory written while idle without a set transaction");

  // A single-voxel access resolves within the read-modify-write window.
  a_vox_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VOX) |=> (state_r == ST_VOX || state_r == ST_DONE))
    else $error("single-voxel access left to an unexpected state");

  // Only a blend reaches the write-back stage of a single-voxel access.
  a_vox_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VOX && p2_r) |-> (item_r.action == vfb_pkg::ACT_BLEND))
    else $error("write-back stage reached by a non-blend access");

endmodule
